>>> src/tprm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprm_pkg: shared types and constants of the tooth period rpm meter
// Holds the stream payloads, configuration register indexes, the datapath
// widths of the rpm division and the request/response of the shared divider.
// ----------------------------------------------------------------------------
package tprm_pkg;

    // Output value format: unsigned Q16.8, 24 bits
    localparam int unsigned RPM_W   = 24;
    localparam logic [RPM_W-1:0] RPM_MAX = 24'hFF_FFFF;

    // Register widths
    localparam int unsigned TEETH_W = 8;
    localparam int unsigned GEAR_W  = 16;
    localparam int unsigned ASIZE_W = 5;
    localparam int unsigned PERIOD_W = 32;

    // Scale factor 60 * CLOCK_HZ fits 36 bits over the whole clock range;
    // it is multiplied in two halves.
    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned SCALE_W  = 36;
    localparam int unsigned HALF_W   = SCALE_W / 2;

    // Divider widths: dividend gear*scale, divisor teeth*period, 24-bit quotient
    localparam int unsigned NUM_W   = GEAR_W + SCALE_W;
    localparam int unsigned DEN_W   = TEETH_W + PERIOD_W;
    localparam int unsigned Q_W     = RPM_W;
    localparam int unsigned QCNT_W  = $clog2(Q_W + 1);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = GEAR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TEETH_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO_Q8 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_SIZE  = 2'd2;

    localparam logic [TEETH_W-1:0] TEETH_RESET = 8'd56;
    localparam logic [GEAR_W-1:0]  GEAR_RESET  = 16'd1024;
    localparam logic [ASIZE_W-1:0] ASIZE_RESET = 5'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
    } t_period_req;

    typedef struct packed {
        logic [RPM_W-1:0] rpm_instant;
        logic [RPM_W-1:0] rpm_average;
        logic             increasing;
    } t_rpm_result;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> src/tprm_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprm_stream_if: valid/ready stream channel
// Carries one payload of type T per request; source drives valid and payload,
// sink drives ready.
// ----------------------------------------------------------------------------
interface tprm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/tprm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprm_div: shared restoring divider
// Saturation check in the start cycle, then one quotient bit per cycle.
// Quotients of 2**24 or more, and a zero divisor, return the maximum.
// ----------------------------------------------------------------------------
module tprm_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire tprm_pkg::t_div_req i_req,
    output tprm_pkg::t_div_rsp   o_rsp
);
    localparam int unsigned HI_W = tprm_pkg::NUM_W - tprm_pkg::Q_W;

    logic                        r_busy;
    logic                        r_sat;
    logic [tprm_pkg::QCNT_W-1:0] r_cnt;
    logic [tprm_pkg::DEN_W-1:0]  r_rem;
    logic [tprm_pkg::DEN_W-1:0]  r_div;
    logic [tprm_pkg::Q_W-1:0]    r_q;

    logic [HI_W-1:0]             w_hi;
    logic                        w_sat;
    logic [tprm_pkg::DEN_W:0]    w_trial;
    logic [tprm_pkg::DEN_W:0]    w_diff;
    logic                        w_ge;

    assign w_hi    = i_req.dividend[tprm_pkg::NUM_W-1:tprm_pkg::Q_W];
    // quotient overflows 24 bits when the upper dividend bits reach the divisor
    assign w_sat   = (i_req.divisor == '0) ||
                     (tprm_pkg::DEN_W'(w_hi) >= i_req.divisor);
    assign w_trial = {r_rem, r_q[tprm_pkg::Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= w_sat ? '0 : tprm_pkg::QCNT_W'(tprm_pkg::Q_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sat <= w_sat;
            r_rem <= tprm_pkg::DEN_W'(w_hi);
            r_div <= i_req.divisor;
            r_q   <= i_req.dividend[tprm_pkg::Q_W-1:0];
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? w_diff[tprm_pkg::DEN_W-1:0] : w_trial[tprm_pkg::DEN_W-1:0];
            r_q   <= {r_q[tprm_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_sat ? tprm_pkg::RPM_MAX : r_q;

endmodule
`default_nettype wire

>>> src/tooth_period_rpm_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tooth_period_rpm_meter: rpm from tooth period with moving average
// Converts each measured tooth period into Q16.8 rpm, averages it over a
// configurable window and flags whether the recent averages are rising.
// ----------------------------------------------------------------------------
//
//  Channel    Modport  Payload                                  Dir
//  ---------  -------  ---------------------------------------  ---
//  i_sample   sink     period_ticks[31:0]                        in
//  o_result   source   rpm_instant[23:0], rpm_average[23:0],     out
//                      increasing
//  i_cfg_*    -        we, idx[1:0], wdata[15:0]                 in
//
//  Each request runs scale/divisor multiplication (S_MUL0, S_MUL1), the
//  rpm pass through the one shared divider, a window update (S_WIN), the
//  average pass (S_ADIV) and a history step (S_HIST); each divider pass
//  is a start, the quotient bits and a finish. A saturated rpm skips the
//  quotient bits of the first pass. The divider sets the rate; the next
//  request is accepted only back in S_IDLE, after the result is registered.
//  Synchronous active-low reset restores the register defaults and empties
//  the window and the history. i_sample.ready is high only while idle; a
//  finished result waiting on o_result stalls only the final history step.
//
module tooth_period_rpm_meter #(
    parameter int MAX_WINDOW    = 16,
    parameter int HISTORY_DEPTH = 5,
    parameter int CLOCK_HZ      = 1000000
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    tprm_stream_if.sink                           i_sample,
    tprm_stream_if.source                         o_result,
    input  wire                                   i_cfg_we,
    input  wire [tprm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [tprm_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    // Window geometry
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = tprm_pkg::RPM_W + $clog2(MAX_WINDOW);
    // History geometry
    localparam int HIDX_W  = $clog2(HISTORY_DEPTH);
    localparam int HFILL_W = $clog2(HISTORY_DEPTH + 1);

    // 60 * CLOCK_HZ, split into two halves for the multiplier
    localparam logic [tprm_pkg::SCALE_W-1:0] RPM_SCALE =
        tprm_pkg::SCALE_W'(64'(tprm_pkg::SECONDS_PER_MINUTE) * 64'(CLOCK_HZ));
    localparam logic [tprm_pkg::HALF_W-1:0] SCALE_LO = RPM_SCALE[tprm_pkg::HALF_W-1:0];
    localparam logic [tprm_pkg::HALF_W-1:0] SCALE_HI =
        RPM_SCALE[tprm_pkg::SCALE_W-1:tprm_pkg::HALF_W];

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_RDIV = 3'd3;
    localparam logic [2:0] S_WIN  = 3'd4;
    localparam logic [2:0] S_ADIV = 3'd5;
    localparam logic [2:0] S_HIST = 3'd6;

    // Control state
    logic [2:0]                    r_state, n_state;
    logic                          r_start, n_start;
    logic                          r_out_valid;
    logic [tprm_pkg::TEETH_W-1:0]  r_teeth;
    logic [tprm_pkg::GEAR_W-1:0]   r_gear;
    logic [tprm_pkg::ASIZE_W-1:0]  r_asize;
    logic [SUM_W-1:0]              r_sum;
    logic [FILL_W-1:0]             r_fill;
    logic [PTR_W-1:0]              r_ptr;
    logic [HFILL_W-1:0]            r_hfill;

    // Payload state
    logic [tprm_pkg::PERIOD_W-1:0] r_period;
    logic [tprm_pkg::NUM_W-1:0]    r_num;
    logic [tprm_pkg::DEN_W-1:0]    r_den;
    logic [tprm_pkg::RPM_W-1:0]    r_rpm;
    logic [tprm_pkg::RPM_W-1:0]    r_avg;
    logic [tprm_pkg::RPM_W-1:0]    r_old;
    logic [tprm_pkg::RPM_W-1:0]    r_win_mem [MAX_WINDOW];
    logic [tprm_pkg::RPM_W-1:0]    r_hist    [HISTORY_DEPTH];
    tprm_pkg::t_rpm_result         r_out;

    // Datapath wires
    tprm_pkg::t_div_req            w_div_req;
    tprm_pkg::t_div_rsp            w_div_rsp;
    logic                          w_accept;
    logic                          w_emit;
    logic [FILL_W-1:0]             w_eff_size;
    logic                          w_win_full;
    logic [FILL_W-1:0]             w_fill_next;
    logic [FILL_W-1:0]             w_ptr_inc;
    logic [PTR_W-1:0]              w_ptr_next;
    logic [SUM_W-1:0]              w_sum_next;
    logic                          w_hist_full;
    logic [tprm_pkg::RPM_W-1:0]    w_oldest;
    logic                          w_cfg_size;

    assign w_accept   = i_sample.valid && i_sample.ready;
    assign w_emit     = (r_state == S_HIST) && (!r_out_valid || o_result.ready);
    assign w_cfg_size = i_cfg_we && (i_cfg_idx == tprm_pkg::CFG_AVERAGE_SIZE);

    // Clamp the window length: zero acts as one, oversize as the full window
    always_comb begin
        if (r_asize == '0) begin
            w_eff_size = FILL_W'(1);
        end else if (32'(r_asize) > 32'(MAX_WINDOW)) begin
            w_eff_size = FILL_W'(MAX_WINDOW);
        end else begin
            w_eff_size = FILL_W'(r_asize);
        end
    end

    // Window update: drop the oldest sample once full, add the new one
    assign w_win_full  = (r_fill >= w_eff_size);
    assign w_fill_next = w_win_full ? r_fill : r_fill + 1'b1;
    assign w_sum_next  = r_sum - (w_win_full ? SUM_W'(r_old) : '0) + SUM_W'(r_rpm);
    assign w_ptr_inc   = FILL_W'(r_ptr) + 1'b1;
    assign w_ptr_next  = (w_ptr_inc >= w_eff_size) ? '0 : w_ptr_inc[PTR_W-1:0];

    // History compare: oldest kept average after this push
    assign w_hist_full = (r_hfill == HFILL_W'(HISTORY_DEPTH));
    always_comb begin
        if (w_hist_full) begin
            w_oldest = r_hist[1];
        end else if (r_hfill == '0) begin
            w_oldest = r_avg;
        end else begin
            w_oldest = r_hist[0];
        end
    end

    // Shared divider: rpm pass divides scaled gear by teeth*period,
    // average pass divides window sum by fill count
    assign w_div_req.start    = r_start;
    assign w_div_req.dividend = r_num;
    assign w_div_req.divisor  = r_den;

    tprm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_start = 1'b1;
                n_state = S_RDIV;
            end
            S_RDIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                n_start = 1'b1;
                n_state = S_ADIV;
            end
            S_ADIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_HIST;
                end
            end
            S_HIST: begin
                // hold until the output register is free
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers, configuration and window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_teeth     <= tprm_pkg::TEETH_RESET;
            r_gear      <= tprm_pkg::GEAR_RESET;
            r_asize     <= tprm_pkg::ASIZE_RESET;
            r_sum       <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_hfill     <= '0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we && (i_cfg_idx == tprm_pkg::CFG_TEETH_PER_REV)) begin
                r_teeth <= i_cfg_wdata[tprm_pkg::TEETH_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == tprm_pkg::CFG_GEAR_RATIO_Q8)) begin
                r_gear <= i_cfg_wdata[tprm_pkg::GEAR_W-1:0];
            end

            // a size write always empties the window; history is kept
            if (w_cfg_size) begin
                r_asize <= i_cfg_wdata[tprm_pkg::ASIZE_W-1:0];
                r_sum   <= '0;
                r_fill  <= '0;
                r_ptr   <= '0;
            end else if (r_state == S_WIN) begin
                r_sum  <= w_sum_next;
                r_fill <= w_fill_next;
                r_ptr  <= w_ptr_next;
            end

            if (w_emit && !w_hist_full) begin
                r_hfill <= r_hfill + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_period <= i_sample.payload.period_ticks;
        end

        unique case (r_state)
            S_MUL0: begin
                r_num <= tprm_pkg::NUM_W'(r_gear) * tprm_pkg::NUM_W'(SCALE_LO);
                r_den <= tprm_pkg::DEN_W'(r_teeth) * tprm_pkg::DEN_W'(r_period);
            end
            S_MUL1: begin
                r_num <= r_num +
                         ((tprm_pkg::NUM_W'(r_gear) * tprm_pkg::NUM_W'(SCALE_HI))
                          << tprm_pkg::HALF_W);
            end
            S_WIN: begin
                r_num <= tprm_pkg::NUM_W'(w_sum_next);
                r_den <= tprm_pkg::DEN_W'(w_fill_next);
            end
            default: begin
            end
        endcase

        if ((r_state == S_RDIV) && w_div_rsp.done) begin
            r_rpm <= w_div_rsp.quotient;
        end
        if ((r_state == S_ADIV) && w_div_rsp.done) begin
            r_avg <= w_div_rsp.quotient;
        end

        if (w_emit) begin
            r_out.rpm_instant <= r_rpm;
            r_out.rpm_average <= r_avg;
            r_out.increasing  <= (r_avg > w_oldest);
        end
    end

    // Window sample memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_WIN) begin
            r_win_mem[r_ptr] <= r_rpm;
        end
        r_old <= r_win_mem[r_ptr];
    end

    // Average history: append until full, then shift toward the oldest slot
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_hist_full) begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HISTORY_DEPTH-1] <= r_avg;
            end else begin
                r_hist[r_hfill[HIDX_W-1:0]] <= r_avg;
            end
        end
    end

    assign i_sample.ready   = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tooth period rpm meter
// Drives tooth periods over the sample stream, keeps its own model of the
// rpm division, the moving-average window and the average history, and
// compares every result against it. Directed register and window cases come
// first, then random speed profiles under three idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    // Block parameters, mirrored for the predictor
    localparam int              WIN_MAX      = 16;
    localparam int              HIST_DEPTH   = 5;
    localparam int              REF_CLOCK_HZ = 1000000;

    // Index past the last register: writes to it must be dropped
    localparam logic [tprm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam longint PERIOD_TOP = 64'h0000_0000_FFFF_FFFF;
    // Far above the slowest legal run (roughly 1.5M time units)
    localparam longint RUN_LIMIT  = 20_000_000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tprm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [tprm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    tprm_stream_if #(.T(tprm_pkg::t_period_req)) sample_ch ();
    tprm_stream_if #(.T(tprm_pkg::t_rpm_result)) result_ch ();

    tooth_period_rpm_meter #(
        .MAX_WINDOW    (WIN_MAX),
        .HISTORY_DEPTH (HIST_DEPTH),
        .CLOCK_HZ      (REF_CLOCK_HZ)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample    (sample_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies, window and history
    // ------------------------------------------------------------------
    logic [tprm_pkg::TEETH_W-1:0] m_teeth = tprm_pkg::TEETH_RESET;
    logic [tprm_pkg::GEAR_W-1:0]  m_gear  = tprm_pkg::GEAR_RESET;
    logic [tprm_pkg::ASIZE_W-1:0] m_asize = tprm_pkg::ASIZE_RESET;

    logic [tprm_pkg::RPM_W-1:0]   win_store [WIN_MAX];
    longint unsigned              win_sum  = 0;
    int unsigned                  win_fill = 0;
    int unsigned                  win_ptr  = 0;
    logic [tprm_pkg::RPM_W-1:0]   avg_hist [HIST_DEPTH];
    int unsigned                  hist_count = 0;

    // Results still owed by the block, oldest first
    tprm_pkg::t_rpm_result        pending_rpm [$];

    int                           error_count = 0;
    int                           src_idle_pct = 25;
    int                           sink_idle_pct = 70;
    int                           stall_left = 0;

    // Append one owed result behind the others
    function automatic void owe_result(tprm_pkg::t_rpm_result res);
        pending_rpm.insert(pending_rpm.size(), res);
    endfunction

    // Take the oldest owed result off the list
    function automatic tprm_pkg::t_rpm_result take_owed();
        tprm_pkg::t_rpm_result res;
        res = pending_rpm[0];
        pending_rpm.delete(0);
        return res;
    endfunction

    // Mirror a register write; an average_size write empties the window
    // but leaves the history alone.
    function automatic void apply_config(logic [tprm_pkg::CFG_IDX_W-1:0] idx,
                                         logic [tprm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tprm_pkg::CFG_TEETH_PER_REV: m_teeth = data[tprm_pkg::TEETH_W-1:0];
            tprm_pkg::CFG_GEAR_RATIO_Q8: m_gear = data[tprm_pkg::GEAR_W-1:0];
            tprm_pkg::CFG_AVERAGE_SIZE: begin
                m_asize  = data[tprm_pkg::ASIZE_W-1:0];
                win_sum  = 0;
                win_fill = 0;
                win_ptr  = 0;
            end
            default: ;
        endcase
    endfunction

    // Compute the result of one period request and advance the model
    function automatic tprm_pkg::t_rpm_result predict_rpm(
        logic [tprm_pkg::PERIOD_W-1:0] period);
        tprm_pkg::t_rpm_result r;
        longint unsigned       num;
        longint unsigned       den;
        longint unsigned       quot;
        longint unsigned       avg;
        int unsigned           span;
        int unsigned           slot;
        num = m_gear;
        num = num * tprm_pkg::SECONDS_PER_MINUTE * 64'(REF_CLOCK_HZ);
        den = m_teeth;
        den = den * period;
        // Zero period or zero teeth leave nothing to divide by: saturate
        if (den == 0) begin
            r.rpm_instant = tprm_pkg::RPM_MAX;
        end else begin
            quot = num / den;
            r.rpm_instant = (quot > tprm_pkg::RPM_MAX) ? tprm_pkg::RPM_MAX
                                                       : quot[tprm_pkg::RPM_W-1:0];
        end

        // Clip the window length into 1..WIN_MAX
        if (m_asize == 0)
            span = 1;
        else if (m_asize > WIN_MAX)
            span = WIN_MAX;
        else
            span = m_asize;
        slot = win_ptr % WIN_MAX;
        if (win_fill < span)
            win_fill++;
        else
            win_sum -= win_store[slot];
        win_store[slot] = r.rpm_instant;
        win_sum += r.rpm_instant;
        slot++;
        if (slot >= span)
            slot = 0;
        win_ptr = slot;
        avg = win_sum / win_fill;
        r.rpm_average = avg[tprm_pkg::RPM_W-1:0];

        // Keep the last HIST_DEPTH averages, shift out the oldest when full
        if (hist_count < HIST_DEPTH) begin
            avg_hist[hist_count] = r.rpm_average;
            hist_count++;
        end else begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
                avg_hist[i] = avg_hist[i + 1];
            avg_hist[HIST_DEPTH - 1] = r.rpm_average;
        end
        r.increasing = avg_hist[hist_count - 1] > avg_hist[0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready with occasional long stalls
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_left != 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle_pct != 0 && $urandom_range(199) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(80, 20);
        end else begin
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk) begin : rpm_check
        tprm_pkg::t_rpm_result got;
        tprm_pkg::t_rpm_result want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.payload;
            if (pending_rpm.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: inst=%h avg=%h inc=%b",
                             got.rpm_instant, got.rpm_average, got.increasing);
            end else begin
                want = take_owed();
                if (got.rpm_instant !== want.rpm_instant ||
                    got.rpm_average !== want.rpm_average ||
                    got.increasing !== want.increasing) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp %h %h %b, got %h %h %b",
                                 want.rpm_instant, want.rpm_average, want.increasing,
                                 got.rpm_instant, got.rpm_average, got.increasing);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one period, idle first at random; leave valid high on return so
    // back-to-back requests never drop it within one step.
    task automatic send_period(input logic [tprm_pkg::PERIOD_W-1:0] period);
        int gap;
        gap = 0;
        if (src_idle_pct != 0) begin
            if ($urandom_range(19) == 0)
                gap = $urandom_range(70, 1);
            else
                while ($urandom_range(99) < src_idle_pct)
                    gap++;
        end
        repeat (gap) begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.payload.period_ticks <= period;
        do @(posedge clk); while (!sample_ch.ready);
        owe_result(predict_rpm(period));
    endtask

    // Drop valid and hold until every result is in and the block is idle
    task automatic wait_meter_idle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_rpm.size() != 0 || !sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [tprm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tprm_pkg::CFG_DATA_W-1:0] data);
        wait_meter_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        apply_config(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Period spread over all magnitudes; masked down to k bits, zero included
    function automatic logic [tprm_pkg::PERIOD_W-1:0] any_period();
        int unsigned k;
        k = $urandom_range(32);
        if (k >= 32)
            return $urandom();
        return $urandom() & ((32'd1 << k) - 32'd1);
    endfunction

    function automatic logic [tprm_pkg::PERIOD_W-1:0] clamp_period(longint v);
        if (v < 1)
            return 32'd1;
        if (v > PERIOD_TOP)
            return 32'hFFFF_FFFF;
        return v[tprm_pkg::PERIOD_W-1:0];
    endfunction

    // One speed profile: steady, speeding up, slowing down, or plain noise
    task automatic send_profile(input int count);
        int     mode;
        longint cur;
        longint delta;
        cur   = any_period();
        if (cur == 0)
            cur = 1;
        delta = cur / 32 + 1;
        mode  = $urandom_range(9);
        for (int i = 0; i < count; i++) begin
            if (mode < 2) begin
                // noise: arbitrary periods with extra zero periods
                send_period(($urandom_range(7) == 0) ? 32'd0 : any_period());
            end else if (mode < 5) begin
                send_period(clamp_period(cur + longint'($urandom_range(
                    int'(2 * delta))) - delta));
            end else if (mode < 8) begin
                // shrinking period: rpm rises
                cur = clamp_period(cur - longint'($urandom_range(int'(delta))));
                send_period(cur[tprm_pkg::PERIOD_W-1:0]);
            end else begin
                cur = clamp_period(cur + longint'($urandom_range(int'(delta))));
                send_period(cur[tprm_pkg::PERIOD_W-1:0]);
            end
        end
    endtask

    // Pick one register and a value, leaning on the extremes
    task automatic reconfigure();
        logic [tprm_pkg::CFG_DATA_W-1:0] data;
        int                              pick;
        data = tprm_pkg::CFG_DATA_W'($urandom());
        pick = $urandom_range(9);
        case ($urandom_range(3))
            0: begin
                if (pick == 0)      data[7:0] = 8'd1;
                else if (pick == 1) data[7:0] = 8'd255;
                else if (pick == 2) data[7:0] = 8'd0;
                cfg_write(tprm_pkg::CFG_TEETH_PER_REV, data);
            end
            1: begin
                if (pick == 0)      data = 16'd1;
                else if (pick == 1) data = 16'hFFFF;
                cfg_write(tprm_pkg::CFG_GEAR_RATIO_Q8, data);
            end
            2: begin
                if (pick < 6)
                    data[4:0] = 5'($urandom_range(4, 1));
                cfg_write(tprm_pkg::CFG_AVERAGE_SIZE, data);
            end
            default: cfg_write(CFG_UNUSED_IDX, data);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: zero period, overflow, tiny rpm, first history entry
    task automatic test_reset_defaults();
        send_period(32'd0);
        send_period(32'd1);
        send_period(32'd65);
        send_period(32'd70000);
        send_period(32'hFFFF_FFFF);
    endtask

    // Register extremes, zero teeth and a write past the last register
    task automatic test_register_extremes();
        // upper data bits must be dropped: teeth becomes zero
        cfg_write(tprm_pkg::CFG_TEETH_PER_REV, 16'hFF00);
        send_period(32'd1000);
        cfg_write(tprm_pkg::CFG_TEETH_PER_REV, 16'h00FF);
        cfg_write(tprm_pkg::CFG_GEAR_RATIO_Q8, 16'hFFFF);
        send_period(32'd1);
        send_period(32'hFFFF_FFFF);
        cfg_write(tprm_pkg::CFG_TEETH_PER_REV, 16'd1);
        cfg_write(tprm_pkg::CFG_GEAR_RATIO_Q8, 16'd1);
        send_period(32'hFFFF_FFFF);
        send_period(32'd60);
        cfg_write(CFG_UNUSED_IDX, 16'hFFFF);
        send_period(32'd60);
    endtask

    // Window length zero, above the maximum, maximum, and a same-value rewrite
    task automatic test_window_sizes();
        cfg_write(tprm_pkg::CFG_AVERAGE_SIZE, 16'd0);
        send_period(32'd30);
        send_period(32'd60);
        send_period(32'd120);
        cfg_write(tprm_pkg::CFG_AVERAGE_SIZE, 16'hFFFF);
        send_period(32'd40);
        send_period(32'd80);
        send_period(32'd20);
        cfg_write(tprm_pkg::CFG_AVERAGE_SIZE, 16'd16);
        send_period(32'd50);
        send_period(32'd25);
        // rewrite of the same size still empties the window
        cfg_write(tprm_pkg::CFG_AVERAGE_SIZE, 16'd16);
        send_period(32'd90);
        send_period(32'd45);
    endtask

    // Random profiles with register changes between them
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int count);
        int sent;
        int len;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(2) == 0)
                reconfigure();
            len = $urandom_range(24, 6);
            send_profile(len);
            sent += len;
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_wdata       = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_window_sizes();
        test_random_traffic(25, 70, 170);
        test_random_traffic(70, 25, 170);
        test_random_traffic(0, 0, 170);

        // Drain, then give stray results a chance to show up
        wait_meter_idle();
        repeat (64) @(posedge clk);
        if (error_count == 0 && pending_rpm.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
src/tprm_pkg.sv
src/tprm_stream_if.sv
src/tprm_div.sv
src/tooth_period_rpm_meter.sv
test/testbench.sv
